// File: src/tcc_pkg.sv
package tcc_pkg;

  localparam int IDX_W = 6;
  localparam int MASK_W = 64;
  localparam int OUT_W = 32;

  localparam int IN_DATA_W = 80;
  localparam int MASK_LSB = 0;
  localparam int FIRST_LSB = MASK_LSB + MASK_W;
  localparam int SECOND_LSB = FIRST_LSB + IDX_W;

  localparam int OUT_DATA_W = 3 * OUT_W;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic             first_ok;
    logic             second_ok;
    logic [IDX_W-1:0] first_bit;
    logic [IDX_W-1:0] second_bit;
    logic [IDX_W-1:0] lo_bit;
  } rd_sel_t;

endpackage

// File: src/tcc_lane.sv
module tcc_lane #(
  parameter int LANE = 0,
  parameter int NUM_BITS = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           acc,
  input  logic [NUM_BITS-1:0]            mask,
  input  logic                           rd,
  input  logic [$clog2(NUM_BITS)-1:0]    rd_hi,
  output logic [COUNT_WIDTH-1:0]         single_snap,
  output logic [COUNT_WIDTH-1:0]         pair_snap
);

  localparam int LANE_W = $clog2(NUM_BITS);
  localparam int LANE_N = 1 << LANE_W;

  logic [COUNT_WIDTH-1:0] single;
  logic [COUNT_WIDTH-1:0] pair_vals [LANE_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      single <= '0;
    end else if (acc && mask[LANE] && (single != '1)) begin
      single <= single + COUNT_WIDTH'(1);
    end
  end

  // pair (LANE, j) lives here for every j above LANE
  for (genvar j = 0; j < LANE_N; j++) begin : g_pair
    if ((j > LANE) && (j < NUM_BITS)) begin : g_cnt
      logic [COUNT_WIDTH-1:0] cnt;
      always_ff @(posedge clk) begin
        if (rst) begin
          cnt <= '0;
        end else if (acc && mask[LANE] && mask[j] && (cnt != '1)) begin
          cnt <= cnt + COUNT_WIDTH'(1);
        end
      end
      assign pair_vals[j] = cnt;
    end else begin : g_none
      assign pair_vals[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      single_snap <= single;
      pair_snap <= pair_vals[rd_hi];
    end
  end

  a_single_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> single >= $past(single))
    else $error("single count decreased");

endmodule

// File: src/tcc_merge.sv
module tcc_merge #(
  parameter int NUM_BITS = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s1_valid,
  input  tcc_pkg::rd_sel_t                sel,
  input  logic [COUNT_WIDTH-1:0]          single_snap [1 << $clog2(NUM_BITS)],
  input  logic [COUNT_WIDTH-1:0]          pair_snap [1 << $clog2(NUM_BITS)],
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [tcc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            adv
);

  localparam int LANE_W = $clog2(NUM_BITS);

  logic [COUNT_WIDTH-1:0] ca, cb, cj;
  logic [tcc_pkg::OUT_W-1:0] oa, ob, oj;

  always_comb begin
    ca = sel.first_ok ? single_snap[sel.first_bit[LANE_W-1:0]] : '0;
    cb = sel.second_ok ? single_snap[sel.second_bit[LANE_W-1:0]] : '0;
    if (!(sel.first_ok && sel.second_ok)) begin
      cj = '0;
    end else if (sel.first_bit == sel.second_bit) begin
      cj = ca;
    end else begin
      cj = pair_snap[sel.lo_bit[LANE_W-1:0]];
    end
  end

  if (COUNT_WIDTH > tcc_pkg::OUT_W) begin : g_clip
    assign oa = (|ca[COUNT_WIDTH-1:tcc_pkg::OUT_W]) ? '1 : ca[tcc_pkg::OUT_W-1:0];
    assign ob = (|cb[COUNT_WIDTH-1:tcc_pkg::OUT_W]) ? '1 : cb[tcc_pkg::OUT_W-1:0];
    assign oj = (|cj[COUNT_WIDTH-1:tcc_pkg::OUT_W]) ? '1 : cj[tcc_pkg::OUT_W-1:0];
  end else begin : g_ext
    assign oa = tcc_pkg::OUT_W'(ca);
    assign ob = tcc_pkg::OUT_W'(cb);
    assign oj = tcc_pkg::OUT_W'(cj);
  end

  assign adv = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      m_tdata <= {oj, ob, oa};
    end
  end

endmodule

// File: src/trigger_coincidence_counter.sv
// Trigger coincidence counter.
// Slave stream carries one transaction per item: tuser is the operation
// (accumulate or read), tdata holds the trigger mask and two bit indices.
// An accumulate adds one event: every single-bit counter whose bit is set and
// every pair counter whose two bits are both set goes up by one, saturating.
// It returns nothing. A read returns one master transaction with the single
// counts of both named bits and their joint count.
// All counters are flip-flops inside one lane per trigger bit, updated in the
// cycle the mask is accepted, so a read right behind an accumulate sees it.
// Throughput: one transaction per cycle, any mix of operations, while the receiver does not stall.
// A read's result is registered in the lane snapshot register, then passes the
// merge mux into the output register.
// Reset clears every counter and the pipeline directly; no clear pass.
// When the receiver stalls, the output register holds its result and the
// snapshot stage holds one more read; tready then drops until space frees.
module trigger_coincidence_counter #(
  parameter int NUM_BITS = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // trigger_mask[63:0], first_bit[69:64], second_bit[75:70], zero pad
  input  logic [tcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // first_count[31:0], second_count[63:32], joint_count[95:64]
  output logic [tcc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int LANE_W = $clog2(NUM_BITS);
  localparam int LANE_N = 1 << LANE_W;

  logic                      accept, acc, rd, adv;
  logic [tcc_pkg::MASK_W-1:0] mask_in;
  logic [tcc_pkg::IDX_W-1:0] first_in, second_in, hi_in, lo_in;
  logic                      s1_valid;
  tcc_pkg::rd_sel_t          s1_sel;
  logic [COUNT_WIDTH-1:0]    single_snap [LANE_N];
  logic [COUNT_WIDTH-1:0]    pair_snap [LANE_N];

  assign mask_in = s_axis_tdata[tcc_pkg::MASK_LSB +: tcc_pkg::MASK_W];
  assign first_in = s_axis_tdata[tcc_pkg::FIRST_LSB +: tcc_pkg::IDX_W];
  assign second_in = s_axis_tdata[tcc_pkg::SECOND_LSB +: tcc_pkg::IDX_W];
  assign hi_in = (first_in > second_in) ? first_in : second_in;
  assign lo_in = (first_in > second_in) ? second_in : first_in;

  assign s_axis_tready = !s1_valid || adv;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign acc = accept && (s_axis_tuser == tcc_pkg::OP_ACCUM);
  assign rd = accept && (s_axis_tuser == tcc_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      s1_sel.first_ok <= (7'(first_in) < 7'(NUM_BITS));
      s1_sel.second_ok <= (7'(second_in) < 7'(NUM_BITS));
      s1_sel.first_bit <= first_in;
      s1_sel.second_bit <= second_in;
      s1_sel.lo_bit <= lo_in;
    end
  end

  for (genvar i = 0; i < LANE_N; i++) begin : g_lane
    if (i < NUM_BITS) begin : g_on
      tcc_lane #(
        .LANE(i),
        .NUM_BITS(NUM_BITS),
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_lane (
        .clk(clk),
        .rst(rst),
        .acc(acc),
        .mask(mask_in[NUM_BITS-1:0]),
        .rd(rd),
        .rd_hi(hi_in[LANE_W-1:0]),
        .single_snap(single_snap[i]),
        .pair_snap(pair_snap[i])
      );
    end else begin : g_off
      assign single_snap[i] = '0;
      assign pair_snap[i] = '0;
    end
  end

  tcc_merge #(
    .NUM_BITS(NUM_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_merge (
    .clk(clk),
    .rst(rst),
    .s1_valid(s1_valid),
    .sel(s1_sel),
    .single_snap(single_snap),
    .pair_snap(pair_snap),
    .m_tready(m_axis_tready),
    .m_tvalid(m_axis_tvalid),
    .m_tdata(m_axis_tdata),
    .adv(adv)
  );

  a_read_enters_stage: assert property (@(posedge clk) disable iff (rst)
    rd |=> s1_valid)
    else $error("accepted read lost before snapshot stage");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared without a read");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_sel.first_bit)
                            && $stable(s1_sel.second_bit)))
    else $error("snapshot stage changed while stalled");

endmodule
